// ===== hw/rtl/ear_pkg.sv =====
// shared types and constants for the euler axis rotation block
// axis codes, register indexes and fixed coefficient widths
// no dependencies

package ear_pkg;

  // axis code held in each slot of axis_order
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_SKIP = 2'd3
  } axis_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COS_X      = 3'd0,
    REG_SIN_X      = 3'd1,
    REG_COS_Y      = 3'd2,
    REG_SIN_Y      = 3'd3,
    REG_COS_Z      = 3'd4,
    REG_SIN_Z      = 3'd5,
    REG_AXIS_ORDER = 3'd6
  } cfg_reg_t;

  // Q1.16 coefficient width and fraction bits
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  // cos 1.0 and sin 0 after reset, order X, Y, Z
  localparam logic [COEF_W-1:0] COS_RESET        = 18'd65536;
  localparam logic [COEF_W-1:0] SIN_RESET        = 18'd0;
  localparam logic [7:0]        AXIS_ORDER_RESET = 8'd36;

endpackage

// ===== hw/rtl/ear_slot.sv =====
// one rotation slot: a multiply stage and a sum/saturate stage
// depends on ear_pkg for axis codes and coefficient widths

module ear_slot import ear_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // upstream side
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [2:0][DW-1:0]   up_vec,
  // slot setup, constant while items are in flight
  input  axis_t                axis,
  input  logic [COEF_W-1:0]    coef_c,
  input  logic [COEF_W-1:0]    coef_s,
  // downstream side
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [2:0][DW-1:0]   dn_vec
);

  localparam int CW     = COEF_W + 1;
  localparam int PROD_W = DW + CW;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [DW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // stage registers
  logic                     va_r, vb_r;
  axis_t                    axis_a_r;
  logic [2:0][DW-1:0]       vec_a_r, vec_b_r, vec_b_nxt;
  logic signed [PROD_W-1:0] m0_r, m1_r, m2_r, m3_r;
  logic                     en_a, en_b;

  // stall chain: a stage moves when empty or when the next one moves
  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  // operand selection; the Y matrix is the common form with sine negated
  logic signed [DW-1:0] pi, pj;
  logic signed [CW-1:0] c_ext, s_ext;

  always_comb begin
    c_ext = {coef_c[COEF_W-1], coef_c};
    s_ext = {coef_s[COEF_W-1], coef_s};
    if (axis == AXIS_Y) begin
      s_ext = -s_ext;
    end
    case (axis)
      AXIS_X: begin
        pi = up_vec[1];
        pj = up_vec[2];
      end
      AXIS_Y: begin
        pi = up_vec[0];
        pj = up_vec[2];
      end
      default: begin
        pi = up_vec[0];
        pj = up_vec[1];
      end
    endcase
  end

  // stage a: four products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      axis_a_r <= axis;
      vec_a_r  <= up_vec;
      m0_r     <= PROD_W'(c_ext) * PROD_W'(pi);
      m1_r     <= PROD_W'(s_ext) * PROD_W'(pj);
      m2_r     <= PROD_W'(s_ext) * PROD_W'(pi);
      m3_r     <= PROD_W'(c_ext) * PROD_W'(pj);
    end
  end

  // stage b: sum, floor shift, saturate and write back
  logic signed [SUM_W-1:0] sum_a, sum_b;
  logic [DW-1:0]           ra, rb;

  always_comb begin
    sum_a = $signed({m0_r[PROD_W-1], m0_r} + {m1_r[PROD_W-1], m1_r}) >>> FRAC_BITS;
    sum_b = $signed({m3_r[PROD_W-1], m3_r} - {m2_r[PROD_W-1], m2_r}) >>> FRAC_BITS;
    ra    = sat(sum_a);
    rb    = sat(sum_b);
    vec_b_nxt = vec_a_r;
    case (axis_a_r)
      AXIS_X: begin
        vec_b_nxt[1] = ra;
        vec_b_nxt[2] = rb;
      end
      AXIS_Y: begin
        vec_b_nxt[0] = ra;
        vec_b_nxt[2] = rb;
      end
      AXIS_Z: begin
        vec_b_nxt[0] = ra;
        vec_b_nxt[1] = rb;
      end
      default: begin
        vec_b_nxt = vec_a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      vec_b_r <= vec_b_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_vec   = vec_b_r;

endmodule

// ===== hw/rtl/euler_axis_rotation.sv =====
// top level of the euler axis rotation block: registers and slot chain
// depends on ear_pkg and ear_slot

// Rotates a Q16.16 vector about X, Y and Z in the order set by axis_order,
// one slot per axis step, using software-supplied Q1.16 cosine and sine.
// Each slot is two register stages (multiply, then sum/floor/saturate),
// and one vector is taken every cycle while out_tready does not stall the
// chain; the throughput is set by the four-multiplier array in each
// slot, which is fully pipelined. Stalls on out_tready ripple back through
// the per-stage valid bits, so empty stages still accept. Configuration
// must be written only while no transaction is in flight.

module euler_axis_rotation import ear_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_SLOTS  = 3
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input vector: x_in, y_in, z_in from the lowest bit up, zero padded
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]          in_tdata,
  // result vector: x_out, y_out, z_out from the lowest bit up, zero padded
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]          out_tdata,
  // register writes
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]                       cfg_index,
  input  logic [COEF_W-1:0]                          cfg_data
);

  localparam int DW      = DATA_WIDTH;
  localparam int TDATA_W = ((3*DW+7)/8)*8;
  localparam int ORD_W   = 2*NUM_SLOTS;

  // configuration registers
  logic [COEF_W-1:0] cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r;
  logic [ORD_W-1:0]  axis_order_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r      <= COS_RESET;
      sin_x_r      <= SIN_RESET;
      cos_y_r      <= COS_RESET;
      sin_y_r      <= SIN_RESET;
      cos_z_r      <= COS_RESET;
      sin_z_r      <= SIN_RESET;
      axis_order_r <= AXIS_ORDER_RESET[ORD_W-1:0];
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS_X:      cos_x_r      <= cfg_data;
        REG_SIN_X:      sin_x_r      <= cfg_data;
        REG_COS_Y:      cos_y_r      <= cfg_data;
        REG_SIN_Y:      sin_y_r      <= cfg_data;
        REG_COS_Z:      cos_z_r      <= cfg_data;
        REG_SIN_Z:      sin_z_r      <= cfg_data;
        REG_AXIS_ORDER: axis_order_r <= cfg_data[ORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // slot chain, link 0 is the input port
  logic [NUM_SLOTS:0]           lk_valid, lk_ready;
  logic [NUM_SLOTS:0][2:0][DW-1:0] lk_vec;

  assign lk_valid[0]  = in_tvalid;
  assign in_tready    = lk_ready[0];
  assign lk_vec[0][0] = in_tdata[DW-1:0];
  assign lk_vec[0][1] = in_tdata[2*DW-1:DW];
  assign lk_vec[0][2] = in_tdata[3*DW-1:2*DW];

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    axis_t             axis;
    logic [COEF_W-1:0] c_sel, s_sel;

    // per-slot coefficient pick
    always_comb begin
      axis = axis_t'(axis_order_r[2*k +: 2]);
      case (axis)
        AXIS_X: begin
          c_sel = cos_x_r;
          s_sel = sin_x_r;
        end
        AXIS_Y: begin
          c_sel = cos_y_r;
          s_sel = sin_y_r;
        end
        AXIS_Z: begin
          c_sel = cos_z_r;
          s_sel = sin_z_r;
        end
        default: begin
          c_sel = cos_x_r;
          s_sel = sin_x_r;
        end
      endcase
    end

    ear_slot #(.DW(DW)) u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lk_valid[k]),
      .up_ready (lk_ready[k]),
      .up_vec   (lk_vec[k]),
      .axis     (axis),
      .coef_c   (c_sel),
      .coef_s   (s_sel),
      .dn_valid (lk_valid[k+1]),
      .dn_ready (lk_ready[k+1]),
      .dn_vec   (lk_vec[k+1])
    );
  end

  // result port is the last slot's output register
  assign out_tvalid           = lk_valid[NUM_SLOTS];
  assign lk_ready[NUM_SLOTS]  = out_tready;
  assign out_tdata            = TDATA_W'({lk_vec[NUM_SLOTS][2], lk_vec[NUM_SLOTS][1],
                                          lk_vec[NUM_SLOTS][0]});

endmodule

// ===== hw/rtl/ear_chk.sv =====
// port-level checker for euler_axis_rotation, bound to the top level
// depends only on the top level's ports

module ear_chk #(
  parameter int TDATA_W = 96
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // pipeline drains on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an idle output stage means every stage can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a taken output frees the whole chain
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // register writes are never held off
  a_cfg_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind euler_axis_rotation ear_chk #(.TDATA_W(TDATA_W)) u_ear_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
